[rtl/binary_max_heap_queue_unit_macros.svh]
// Assertion macros for the binary max heap queue unit.
`ifndef BINARY_MAX_HEAP_QUEUE_UNIT_MACROS_SVH
`define BINARY_MAX_HEAP_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define BMHQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define BMHQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bmhq_pkg.sv]
// Shared types and codes of the binary max heap queue unit.
`default_nettype none

package bmhq_pkg;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RD_ROOT     = 2'd0,
    RD_LAST     = 2'd1,
    RD_PARENT   = 2'd2,
    RD_CHILDREN = 2'd3
  } rd_sel_e;

  typedef struct packed {
    logic               action;
    logic signed [31:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic [10:0]        item_count;
    logic               is_empty;
  } out_rsp_t;

  typedef struct packed {
    logic    take;
    logic    set_status;
    status_e status;
    logic    ins_start;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    grab_result;
    logic    grab_last;
    logic    up_step;
    logic    dn_step;
    logic    wr_v;
    logic    emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_remove;
    logic is_full;
    logic is_empty;
    logic count_one;
    logic parent_zero;
    logic up_wins;
    logic left_ok;
    logic child_wins;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

[rtl/bmhq_ctrl.sv]
// Controller state machine of the binary max heap queue unit.
`default_nettype none

module bmhq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bmhq_pkg::dp_sts_t    sts_i,
  output bmhq_pkg::ctrl_cmd_t  cmd_o
);
  import bmhq_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_START   = 10'b00_0000_0010,
    S_RM_ROOT = 10'b00_0000_0100,
    S_RM_LAST = 10'b00_0000_1000,
    S_UP_RD   = 10'b00_0001_0000,
    S_UP_CMP  = 10'b00_0010_0000,
    S_DN_RD   = 10'b00_0100_0000,
    S_DN_CMP  = 10'b00_1000_0000,
    S_WRV     = 10'b01_0000_0000,
    S_DONE    = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = ST_OK;
    cmd_o.rd_sel = RD_ROOT;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        if (!sts_i.is_remove) begin
          if (sts_i.is_full) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_FULL;
            state_d          = S_DONE;
          end else begin
            cmd_o.ins_start = 1'b1;
            state_d = sts_i.is_empty ? S_WRV : S_UP_RD;
          end
        end else if (sts_i.is_empty) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_EMPTY;
          state_d          = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_ROOT;
          state_d      = S_RM_ROOT;
        end
      end
      S_RM_ROOT: begin
        cmd_o.grab_result = 1'b1;
        if (sts_i.count_one) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LAST;
          state_d      = S_RM_LAST;
        end
      end
      S_RM_LAST: begin
        cmd_o.grab_last = 1'b1;
        state_d         = S_DN_RD;
      end
      S_UP_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_PARENT;
        state_d      = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (sts_i.up_wins) begin
          cmd_o.up_step = 1'b1;
          state_d = sts_i.parent_zero ? S_WRV : S_UP_RD;
        end else begin
          cmd_o.wr_v = 1'b1;
          state_d    = S_DONE;
        end
      end
      S_DN_RD: begin
        if (sts_i.left_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_CHILDREN;
          state_d      = S_DN_CMP;
        end else begin
          state_d = S_WRV;
        end
      end
      S_DN_CMP: begin
        if (sts_i.child_wins) begin
          cmd_o.dn_step = 1'b1;
          state_d       = S_DN_RD;
        end else begin
          cmd_o.wr_v = 1'b1;
          state_d    = S_DONE;
        end
      end
      S_WRV: begin
        cmd_o.wr_v = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/bmhq_datapath.sv]
// Datapath of the binary max heap queue unit: heap memory, index logic, output register.
`default_nettype none

module bmhq_datapath #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bmhq_pkg::ctrl_cmd_t  cmd_i,
  output bmhq_pkg::dp_sts_t    sts_o,
  input  bmhq_pkg::in_req_t    in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bmhq_pkg::out_rsp_t   out_rsp_o
);
  import bmhq_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = AW + 2;

  logic signed [31:0] heap_mem [CAPACITY];

  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic signed [31:0] v_q, v_d;
  logic signed [31:0] result_q, result_d;
  logic [1:0]         status_q, status_d;
  logic               action_q, action_d;
  logic signed [31:0] rd_a_q, rd_b_q;
  logic               out_valid_q;
  out_rsp_t           out_rsp_q;

  logic [XW-1:0]      left_x, right_x, count_x;
  logic [AW-1:0]      parent, last_idx, rd_addr_a, rd_addr_b, win_idx;
  logic               left_ok, right_ok, left_wins, right_wins;
  logic signed [31:0] best_val, win_val, wr_data;
  logic               wr_en, out_free;

  assign left_x   = XW'({pos_q, 1'b1});
  assign right_x  = left_x + XW'(1);
  assign count_x  = XW'(count_q);
  assign left_ok  = (left_x < count_x);
  assign right_ok = (right_x < count_x);
  assign parent   = (pos_q - AW'(1)) >> 1;
  assign last_idx = AW'(count_q - CW'(1));

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_ROOT:     rd_addr_a = '0;
      RD_LAST:     rd_addr_a = last_idx;
      RD_PARENT:   rd_addr_a = parent;
      RD_CHILDREN: rd_addr_a = AW'(left_x);
      default:     rd_addr_a = '0;
    endcase
  end
  assign rd_addr_b = AW'(right_x);

  assign left_wins  = (rd_a_q > v_q);
  assign best_val   = left_wins ? rd_a_q : v_q;
  assign right_wins = right_ok && (rd_b_q > best_val);
  assign win_val    = right_wins ? rd_b_q : rd_a_q;
  assign win_idx    = right_wins ? AW'(right_x) : AW'(left_x);

  assign wr_en   = cmd_i.up_step | cmd_i.dn_step | cmd_i.wr_v;
  assign wr_data = cmd_i.up_step ? rd_a_q : (cmd_i.dn_step ? win_val : v_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      heap_mem[pos_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_a_q <= heap_mem[rd_addr_a];
      rd_b_q <= heap_mem[rd_addr_b];
    end
  end

  always_comb begin
    count_d  = count_q;
    pos_d    = pos_q;
    v_d      = v_q;
    result_d = result_q;
    status_d = status_q;
    action_d = action_q;
    if (cmd_i.take) begin
      action_d = in_req_i.action;
      v_d      = in_req_i.value;
      result_d = '0;
      status_d = ST_OK;
    end
    if (cmd_i.set_status) begin
      status_d = cmd_i.status;
    end
    if (cmd_i.ins_start) begin
      pos_d   = AW'(count_q);
      count_d = count_q + CW'(1);
    end
    if (cmd_i.grab_result) begin
      result_d = rd_a_q;
      count_d  = count_q - CW'(1);
    end
    if (cmd_i.grab_last) begin
      v_d   = rd_a_q;
      pos_d = '0;
    end
    if (cmd_i.up_step) begin
      pos_d = parent;
    end
    if (cmd_i.dn_step) begin
      pos_d = win_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    v_q      <= v_d;
    result_q <= result_d;
    status_q <= status_d;
    action_q <= action_d;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_rsp_q.result_value <= result_q;
      out_rsp_q.status       <= status_q;
      out_rsp_q.item_count   <= 11'(count_q);
      out_rsp_q.is_empty     <= (count_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  assign sts_o.is_remove   = (action_q == ACT_REMOVE);
  assign sts_o.is_full     = (count_q == CW'(CAPACITY));
  assign sts_o.is_empty    = (count_q == '0);
  assign sts_o.count_one   = (count_q == CW'(1));
  assign sts_o.parent_zero = (parent == '0);
  assign sts_o.up_wins     = (v_q > rd_a_q);
  assign sts_o.left_ok     = left_ok;
  assign sts_o.child_wins  = left_wins || right_wins;
  assign sts_o.out_free    = out_free;

endmodule

`default_nettype wire

[rtl/binary_max_heap_queue_unit.sv]
// Dropped inserts and empty removes go straight to the response; other inserts compare with
// the parent per level climbed, with a write state of its own if the climb reaches the root;
// other removes read the root and, if more remain, the last element and children per level.
// One request at a time: the next is taken the cycle after the result is registered.
// Reset clears the element count and control; heap memory holds stale data, no clearing pass.
// Top level of the binary max heap queue unit.
`default_nettype none

module binary_max_heap_queue_unit #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bmhq_pkg::in_req_t   in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bmhq_pkg::out_rsp_t  out_rsp_o
);
  import bmhq_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  bmhq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bmhq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

[rtl/bmhq_checker.sv]
// Port checker of the binary max heap queue unit and its bind.
`default_nettype none
`include "binary_max_heap_queue_unit_macros.svh"

module bmhq_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  bmhq_pkg::in_req_t   in_req_i,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  bmhq_pkg::out_rsp_t  out_rsp_o
);
  import bmhq_pkg::*;

  logic in_take;
  assign in_take = in_valid_i && !in_stall_o && (in_req_i.action == ACT_INSERT
                   || in_req_i.action == ACT_REMOVE);

  `BMHQ_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o), "stalled response changed")
  `BMHQ_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, in_take, in_stall_o, "second request taken while busy")
  `BMHQ_ASSERT_IMP(a_empty_remove, clk_i, rst_ni, out_valid_o && (out_rsp_o.status == ST_EMPTY), out_rsp_o.is_empty && (out_rsp_o.result_value == '0), "remove from empty queue misreported")
  `BMHQ_ASSERT_IMP(a_full_insert, clk_i, rst_ni, out_valid_o && (out_rsp_o.status == ST_FULL), !out_rsp_o.is_empty && (out_rsp_o.result_value == '0), "dropped insert misreported")

endmodule

bind binary_max_heap_queue_unit bmhq_checker u_bmhq_checker (.*);

`default_nettype wire
